[src/gdad_pkg.sv]
// ----------------------------------------------------------------------------
// gdad_pkg
// Types, constants and calendar tables shared by the date adder modules.
// ----------------------------------------------------------------------------
package gdad_pkg;

  // Number of low bits of the day count that take part in the addition.
  localparam int unsigned ADD_DAYS_BITS = 16;
  localparam int unsigned CNT_W         = ADD_DAYS_BITS;

  localparam logic [13:0] YEAR_MIN  = 14'd1500;
  localparam logic [13:0] YEAR_MAX  = 14'd9999;
  localparam logic [13:0] CYCLE_LEN = 14'd400;
  localparam logic [8:0]  CYCLE_END = 9'd399;

  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_DEC = 4'd12;

  localparam logic [4:0]  FEB_DAYS  = 5'd28;
  localparam logic [4:0]  LEAP_FEB  = 5'd29;

  // Depth of the queue between the front and the back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [3:0]  month_in;
    logic [5:0]  day_in;
    logic [13:0] year_in;
    logic [15:0] add_days;
  } in_t;

  typedef struct packed {
    logic [3:0]  new_month;
    logic [4:0]  new_day;
    logic [13:0] new_year;
    logic        is_leap;
    logic [4:0]  month_length;
    logic [8:0]  day_of_year;
    logic [8:0]  days_left_in_year;
    logic        input_fixed;
  } out_t;

  // Facts about the validated start date, passed through to the result.
  typedef struct packed {
    logic        is_leap;
    logic [4:0]  month_length;
    logic [8:0]  day_of_year;
    logic [8:0]  days_left_in_year;
    logic        input_fixed;
  } report_t;

  // One classified item waiting for the month walk.
  typedef struct packed {
    logic [3:0]       month;
    logic [4:0]       day;
    logic [13:0]      year;
    logic [8:0]       year_mod400;
    logic [CNT_W-1:0] count;
    report_t          report;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Gregorian leap rule from the year modulo 400 and the two low year bits.
  function automatic logic leap_of(logic [8:0] mod400, logic [1:0] low_bits);
    logic century;
    century = (mod400 == 9'd100) || (mod400 == 9'd200) || (mod400 == 9'd300);
    return (mod400 == 9'd0) || (!century && (low_bits == 2'd0));
  endfunction

  // Days in a month; only called with months 1..12.
  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = leap ? LEAP_FEB : FEB_DAYS;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Days of a common year before the first of the month.
  function automatic logic [8:0] days_before(logic [3:0] m);
    logic [8:0] n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

[src/gdad_front.sv]
// ----------------------------------------------------------------------------
// gdad_front
// Accepts an item, validates the start date and pushes it to the queue.
// ----------------------------------------------------------------------------
module gdad_front import gdad_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_t       in_data_i,
  input  q_status_t q_status_i,
  output logic      push_o,
  output entry_t    push_data_o
);

  localparam logic F_IDLE   = 1'b0;
  localparam logic F_REDUCE = 1'b1;

  logic             state_q, state_d;
  logic [3:0]       m_q, m_d;
  logic [5:0]       d_q, d_d;
  logic [13:0]      y_q, y_d;
  logic [13:0]      r_q, r_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             fixed_q, fixed_d;

  logic       m_ok, y_ok, accept;
  logic       reduced, leap, day_bad;
  logic [4:0] ml;
  logic [4:0] day_v;
  logic [8:0] doy;

  assign in_stall_o = (state_q != F_IDLE);
  assign accept     = in_valid_i && (state_q == F_IDLE);

  assign m_ok = (in_data_i.month_in >= MONTH_JAN) && (in_data_i.month_in <= MONTH_DEC);
  assign y_ok = (in_data_i.year_in >= YEAR_MIN) && (in_data_i.year_in <= YEAR_MAX);

  // The year is brought below 400 by repeated subtraction before classifying.
  assign reduced = (r_q < CYCLE_LEN);
  assign leap    = leap_of(r_q[8:0], y_q[1:0]);
  assign ml      = month_len(m_q, leap);
  assign day_bad = (d_q == 6'd0) || (d_q > {1'b0, ml});
  assign day_v   = day_bad ? 5'd1 : d_q[4:0];
  assign doy     = days_before(m_q) + {8'd0, leap && (m_q > MONTH_FEB)} + {4'd0, day_v};

  assign push_o = (state_q == F_REDUCE) && reduced && !q_status_i.full;

  always_comb begin
    push_data_o.month                    = m_q;
    push_data_o.day                      = day_v;
    push_data_o.year                     = y_q;
    push_data_o.year_mod400              = r_q[8:0];
    push_data_o.count                    = cnt_q;
    push_data_o.report.is_leap           = leap;
    push_data_o.report.month_length      = ml;
    push_data_o.report.day_of_year       = doy;
    push_data_o.report.days_left_in_year = 9'd365 + {8'd0, leap} - doy;
    push_data_o.report.input_fixed       = fixed_q || day_bad;
  end

  always_comb begin
    state_d = state_q;
    m_d     = m_q;
    d_d     = d_q;
    y_d     = y_q;
    r_d     = r_q;
    cnt_d   = cnt_q;
    fixed_d = fixed_q;
    if (accept) begin
      state_d = F_REDUCE;
      m_d     = m_ok ? in_data_i.month_in : MONTH_JAN;
      d_d     = in_data_i.day_in;
      y_d     = y_ok ? in_data_i.year_in : YEAR_MIN;
      r_d     = y_ok ? in_data_i.year_in : YEAR_MIN;
      cnt_d   = CNT_W'(in_data_i.add_days);
      fixed_d = !m_ok || !y_ok;
    end else if (state_q == F_REDUCE) begin
      if (!reduced) begin
        r_d = r_q - CYCLE_LEN;
      end else if (!q_status_i.full) begin
        state_d = F_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q     <= m_d;
    d_q     <= d_d;
    y_q     <= y_d;
    r_q     <= r_d;
    cnt_q   <= cnt_d;
    fixed_q <= fixed_d;
  end

endmodule

[src/gdad_queue.sv]
// ----------------------------------------------------------------------------
// gdad_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module gdad_queue import gdad_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  entry_t    push_data_i,
  input  logic      pop_i,
  output entry_t    pop_data_o,
  output q_status_t status_o
);

  entry_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wptr_q, rptr_q;
  logic [QCNT_W-1:0]   cnt_q;
  logic                do_push, do_pop;

  assign status_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_data_o     = mem_q[rptr_q];

  function automatic logic [QPTR_W-1:0] next_ptr(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= next_ptr(wptr_q);
      end
      if (do_pop) begin
        rptr_q <= next_ptr(rptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

[src/gdad_back.sv]
// ----------------------------------------------------------------------------
// gdad_back
// Walks month by month to add the day count and holds the result register.
// ----------------------------------------------------------------------------
module gdad_back import gdad_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_status_t q_status_i,
  input  entry_t    pop_data_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_t      out_data_o
);

  localparam logic B_IDLE = 1'b0;
  localparam logic B_WALK = 1'b1;

  logic             state_q, state_d;
  logic [3:0]       cm_q, cm_d;
  logic [4:0]       cd_q, cd_d;
  logic [13:0]      cy_q, cy_d;
  logic [8:0]       r400_q, r400_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  report_t          rep_q, rep_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  logic             leap, fits, out_free;
  logic [4:0]       len;
  logic [CNT_W:0]   sum;
  logic [5:0]       used;

  assign leap     = leap_of(r400_q, cy_q[1:0]);
  assign len      = month_len(cm_q, leap);
  assign sum      = {{(CNT_W - 4){1'b0}}, cd_q} + {1'b0, rem_q};
  assign fits     = (sum <= {{(CNT_W - 4){1'b0}}, len});
  // Days consumed to reach the first of the next month.
  assign used     = {1'b0, len} - {1'b0, cd_q} + 6'd1;
  assign out_free = !out_valid_q || !out_stall_i;

  assign pop_o       = (state_q == B_IDLE) && !q_status_i.empty;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    cm_d        = cm_q;
    cd_d        = cd_q;
    cy_d        = cy_q;
    r400_d      = r400_q;
    rem_d       = rem_q;
    rep_d       = rep_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    unique case (state_q)
      B_IDLE: begin
        if (pop_o) begin
          state_d = B_WALK;
          cm_d    = pop_data_i.month;
          cd_d    = pop_data_i.day;
          cy_d    = pop_data_i.year;
          r400_d  = pop_data_i.year_mod400;
          rem_d   = pop_data_i.count;
          rep_d   = pop_data_i.report;
        end
      end
      default: begin
        if (fits) begin
          // Final month reached; wait here until the result register frees.
          if (out_free) begin
            state_d                 = B_IDLE;
            out_valid_d             = 1'b1;
            out_d.new_month         = cm_q;
            out_d.new_day           = sum[4:0];
            out_d.new_year          = cy_q;
            out_d.is_leap           = rep_q.is_leap;
            out_d.month_length      = rep_q.month_length;
            out_d.day_of_year       = rep_q.day_of_year;
            out_d.days_left_in_year = rep_q.days_left_in_year;
            out_d.input_fixed       = rep_q.input_fixed;
          end
        end else begin
          rem_d = rem_q - {{(CNT_W - 6){1'b0}}, used};
          cd_d  = 5'd1;
          if (cm_q == MONTH_DEC) begin
            cm_d = MONTH_JAN;
            // The year saturates; the months keep cycling through its last year.
            if (cy_q < YEAR_MAX) begin
              cy_d   = cy_q + 14'd1;
              r400_d = (r400_q == CYCLE_END) ? 9'd0 : r400_q + 9'd1;
            end
          end else begin
            cm_d = cm_q + 4'd1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cm_q   <= cm_d;
    cd_q   <= cd_d;
    cy_q   <= cy_d;
    r400_q <= r400_d;
    rem_q  <= rem_d;
    rep_q  <= rep_d;
    out_q  <= out_d;
  end

endmodule

[src/gregorian_date_add_days.sv]
// ----------------------------------------------------------------------------
// gregorian_date_add_days
// Validates a start date and adds a day count to it, month by month.
// ----------------------------------------------------------------------------
// Flow: the front reduces the year modulo 400 by subtracting 400 once a
// cycle and pushes the item once the queue has room; the back pops it and
// walks one month per cycle until the count fits, then waits for the result
// register to be free before it writes the result.
// Throughput: the month walk sets it; one item at a time per part, with a
// two-entry queue letting the front classify the next item meanwhile.
// Reset clears the control state, the queue and the result valid flag.
module gregorian_date_add_days import gdad_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  q_status_t q_status;
  logic      push, pop;
  entry_t    push_data, pop_data;

  gdad_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  gdad_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  gdad_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // The front never pushes into a full queue and the back never pops an empty one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_status.full) && !(pop && q_status.empty))
    else $error("queue overflow or underflow");

  // An accepted item keeps the front busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("front took a second item while classifying");

  // Result dates stay inside the calendar range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.new_month >= MONTH_JAN) &&
                    (out_data_o.new_month <= MONTH_DEC) &&
                    (out_data_o.new_day != 5'd0) &&
                    (out_data_o.new_year >= YEAR_MIN) &&
                    (out_data_o.new_year <= YEAR_MAX))
    else $error("result date out of range");

  // Day of year and days left always add up to the year length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.day_of_year + out_data_o.days_left_in_year ==
                     9'd365 + {8'd0, out_data_o.is_leap}))
    else $error("day of year inconsistent with year length");

endmodule
